// File: src/rds_pkg.sv
// Shared types and constants for the room dispatch scheduler.
`timescale 1ns / 1ps

package rds_pkg;

    // Field widths of the request and result items.
    localparam int TIME_IN_W  = 32;
    localparam int TIME_W     = 40;
    localparam int COUNT_W    = 20;
    localparam int ROOM_OUT_W = 4;
    localparam int CFG_W      = 5;

    // Saturation limits and the room count after reset.
    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic load;      // capture a new request and clear the scan
        logic scan;      // read the next room's free time
        logic cnt_rd;    // read the use count of the chosen room
        logic commit;    // write back the room and update the leader
        logic out_load;  // move the staged result into the output register
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_last; // the read issued this cycle is the last active room
    } t_dp_status;

endpackage

// File: src/rds_if.sv
// Channel interfaces: job requests, results and the room count register.
`timescale 1ns / 1ps

interface rds_job_if;
    import rds_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TIME_IN_W-1:0] start_time;
    logic [TIME_IN_W-1:0] end_time;
    modport source (output valid, start_time, end_time, input ready);
    modport sink   (input valid, start_time, end_time, output ready);
endinterface

interface rds_result_if;
    import rds_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ROOM_OUT_W-1:0] assigned_room;
    logic [TIME_W-1:0]     actual_begin;
    logic [TIME_W-1:0]     actual_finish;
    logic [ROOM_OUT_W-1:0] most_booked_room;
    logic [COUNT_W-1:0]    most_booked_count;
    modport source (output valid, assigned_room, actual_begin, actual_finish,
                    most_booked_room, most_booked_count, input ready);
    modport sink   (input valid, assigned_room, actual_begin, actual_finish,
                    most_booked_room, most_booked_count, output ready);
endinterface

interface rds_cfg_if;
    import rds_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] room_count;
    modport source (output valid, room_count, input ready);
    modport sink   (input valid, room_count, output ready);
endinterface

// File: src/room_dispatch_scheduler_unit.sv
// Top level of the room dispatch scheduler: controller, datapath and checks.
`timescale 1ns / 1ps

// Channel   | Dir | Handshake    | Payload
// i_job     | in  | valid/ready  | start_time, end_time
// o_result  | out | valid/ready  | assigned_room, actual_begin, actual_finish,
//           |     |              | most_booked_room, most_booked_count
// i_cfg     | in  | valid/ready  | room_count (always ready)
//
// A job is accepted, then the free-time memory is read once per active room through
// its single read port; the last read is compared, the chosen room's use count is
// read, the result is written back and finally handed off.
// Reset is synchronous; it clears the per-room written flags, so no clearing pass.
// A finished result waits in the output register; the next job is accepted and
// worked meanwhile and holds only in its hand-off cycle until the register frees.

module room_dispatch_scheduler_unit #(
    parameter int ROOMS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rds_job_if.sink      i_job,
    rds_result_if.source o_result,
    rds_cfg_if.sink      i_cfg
);
    import rds_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    assign i_cfg.ready = 1'b1;

    // Controller.
    rds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (i_job.valid),
        .o_job_ready (i_job.ready),
        .o_res_valid (o_result.valid),
        .i_res_ready (o_result.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Datapath.
    rds_datapath #(
        .ROOMS (ROOMS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg_valid         (i_cfg.valid),
        .i_cfg_room_count    (i_cfg.room_count),
        .i_start_time        (i_job.start_time),
        .i_end_time          (i_job.end_time),
        .o_assigned_room     (o_result.assigned_room),
        .o_actual_begin      (o_result.actual_begin),
        .o_actual_finish     (o_result.actual_finish),
        .o_most_booked_room  (o_result.most_booked_room),
        .o_most_booked_count (o_result.most_booked_count)
    );

    // The controller issues at most one datapath command per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.scan, w_cmd.cnt_rd, w_cmd.commit, w_cmd.out_load}))
        else $error("more than one datapath command in a cycle");

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_result.valid || o_result.ready))
        else $error("result register overwritten while still pending");

    // The scan stops after the last active room.
    a_scan_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.scan && w_sts.scan_last) |=> !w_cmd.scan)
        else $error("scan ran past the last active room");

    // A commit is followed by a hand-off attempt, never by a new request.
    a_commit_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> !w_cmd.load && !i_job.ready)
        else $error("new request accepted before the result was handed off");

endmodule

// File: src/rds_ctrl.sv
// Controller state machine: sequences accept, scan, update and result hand-off.
`timescale 1ns / 1ps

module rds_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output rds_pkg::t_dp_cmd    o_cmd,
    input  rds_pkg::t_dp_status i_sts
);
    import rds_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_CNT   = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    // The output register can take a new result when empty or being drained.
    assign w_out_free  = !r_out_valid || i_res_ready;
    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CNT;
            end
            S_CNT: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid sets on a load and clears once the result is taken.
    always_comb begin
        n_out_valid = r_out_valid && !i_res_ready;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: src/rds_datapath.sv
// Datapath: room memories, scan compare, saturating update and result registers.
`timescale 1ns / 1ps

module rds_datapath #(
    parameter int ROOMS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rds_pkg::t_dp_cmd                 i_cmd,
    output rds_pkg::t_dp_status              o_sts,
    input  logic                             i_cfg_valid,
    input  logic [rds_pkg::CFG_W-1:0]        i_cfg_room_count,
    input  logic [rds_pkg::TIME_IN_W-1:0]    i_start_time,
    input  logic [rds_pkg::TIME_IN_W-1:0]    i_end_time,
    output logic [rds_pkg::ROOM_OUT_W-1:0]   o_assigned_room,
    output logic [rds_pkg::TIME_W-1:0]       o_actual_begin,
    output logic [rds_pkg::TIME_W-1:0]       o_actual_finish,
    output logic [rds_pkg::ROOM_OUT_W-1:0]   o_most_booked_room,
    output logic [rds_pkg::COUNT_W-1:0]      o_most_booked_count
);
    import rds_pkg::*;

    localparam int IW = (ROOMS > 1) ? $clog2(ROOMS) : 1;

    // Room memories and their written flags.
    logic [TIME_W-1:0]  r_mem_time [ROOMS];
    logic [COUNT_W-1:0] r_mem_cnt  [ROOMS];
    logic [ROOMS-1:0]   r_written;

    logic [CFG_W-1:0]     r_room_count;
    logic [TIME_IN_W-1:0] r_start;
    logic [TIME_IN_W-1:0] r_dur;
    logic [IW-1:0]        r_rd_idx;
    logic [TIME_W-1:0]    r_rd_time;
    logic                 r_rd_time_hit;
    logic                 r_cmp_vld;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_found;
    logic [TIME_W-1:0]    r_best;
    logic [IW-1:0]        r_pick;
    logic [COUNT_W-1:0]   r_rd_cnt;
    logic                 r_rd_cnt_hit;
    logic [IW-1:0]        r_lead_room;
    logic [COUNT_W-1:0]   r_lead_cnt;
    logic [IW-1:0]        r_res_room;
    logic [TIME_W-1:0]    r_res_begin;
    logic [TIME_W-1:0]    r_res_finish;

    logic [8:0]           w_cfg9;
    logic [8:0]           w_active;
    logic [IW-1:0]        w_last_idx;
    logic [TIME_W-1:0]    w_cmp_time;
    logic [TIME_W-1:0]    w_begin;
    logic [TIME_W:0]      w_sum;
    logic [TIME_W-1:0]    w_finish;
    logic [COUNT_W-1:0]   w_cnt_old;
    logic [COUNT_W-1:0]   w_cnt_new;
    logic                 w_lead_take;

    // Active room count: zero acts as one, above the built count clamps.
    always_comb begin
        w_cfg9   = {4'd0, r_room_count};
        w_active = w_cfg9;
        if (r_room_count == '0) begin
            w_active = 9'd1;
        end else if (w_cfg9 > 9'(ROOMS)) begin
            w_active = 9'(ROOMS);
        end
        w_last_idx = IW'(w_active - 9'd1);
    end

    assign o_sts.scan_last = (r_rd_idx == w_last_idx);

    // A room never written reads as free at time zero with no bookings.
    assign w_cmp_time = r_rd_time_hit ? r_rd_time : '0;
    assign w_cnt_old  = r_rd_cnt_hit ? r_rd_cnt : '0;

    // Commit arithmetic: begin time, saturating finish and count, leader test.
    always_comb begin
        w_begin     = r_found ? {{(TIME_W-TIME_IN_W){1'b0}}, r_start} : r_best;
        w_sum       = {1'b0, w_begin} + {{(TIME_W+1-TIME_IN_W){1'b0}}, r_dur};
        w_finish    = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];
        w_cnt_new   = (w_cnt_old == COUNT_MAX) ? w_cnt_old : w_cnt_old + 1'b1;
        w_lead_take = (w_cnt_new > r_lead_cnt) ||
                      ((w_cnt_new == r_lead_cnt) && (r_pick < r_lead_room));
    end

    // Memory reads and writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_time <= r_mem_time[r_rd_idx];
        end
        if (i_cmd.cnt_rd) begin
            r_rd_cnt <= r_mem_cnt[r_pick];
        end
        if (i_cmd.commit) begin
            r_mem_time[r_pick] <= w_finish;
            r_mem_cnt[r_pick]  <= w_cnt_new;
        end
    end

    // Control state: config register, written flags, scan tracking, leader.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_count <= CFG_RESET;
            r_written    <= '0;
            r_cmp_vld    <= 1'b0;
            r_rd_idx     <= '0;
            r_lead_room  <= '0;
            r_lead_cnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_room_count <= i_cfg_room_count;
            end
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_rd_idx <= '0;
            end else if (i_cmd.scan) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (i_cmd.commit) begin
                r_written[r_pick] <= 1'b1;
                if (w_lead_take) begin
                    r_lead_room <= r_pick;
                    r_lead_cnt  <= w_cnt_new;
                end
            end
        end
    end

    // Scan payload: request capture, per-room compare and result staging.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_time_hit <= r_written[r_rd_idx];
            r_cmp_idx     <= r_rd_idx;
        end
        if (i_cmd.cnt_rd) begin
            r_rd_cnt_hit <= r_written[r_pick];
        end
        if (i_cmd.load) begin
            r_start <= i_start_time;
            r_dur   <= (i_end_time > i_start_time) ? i_end_time - i_start_time : '0;
            r_found <= 1'b0;
            r_best  <= '0;
            r_pick  <= '0;
        end else if (r_cmp_vld && !r_found) begin
            if (w_cmp_time <= {{(TIME_W-TIME_IN_W){1'b0}}, r_start}) begin
                r_found <= 1'b1;
                r_pick  <= r_cmp_idx;
            end else if ((r_cmp_idx == '0) || (w_cmp_time < r_best)) begin
                r_best <= w_cmp_time;
                r_pick <= r_cmp_idx;
            end
        end
        if (i_cmd.commit) begin
            r_res_room   <= r_pick;
            r_res_begin  <= w_begin;
            r_res_finish <= w_finish;
        end
        if (i_cmd.out_load) begin
            o_assigned_room     <= ROOM_OUT_W'(r_res_room);
            o_actual_begin      <= r_res_begin;
            o_actual_finish     <= r_res_finish;
            o_most_booked_room  <= ROOM_OUT_W'(r_lead_room);
            o_most_booked_count <= r_lead_cnt;
        end
    end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the room dispatch scheduler, with its own booking predictor.
`timescale 1ns / 1ps

module tb;
    import rds_pkg::*;

    localparam int ROOMS_BUILT   = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = ROOMS_BUILT + 8;
    localparam int PHASE_JOBS    = 45;
    localparam int SATURATE_JOBS = 260;

    // One expected booking, in the field order of the result channel.
    typedef struct packed {
        logic [ROOM_OUT_W-1:0] room;
        logic [TIME_W-1:0]     begins;
        logic [TIME_W-1:0]     finishes;
        logic [ROOM_OUT_W-1:0] top_room;
        logic [COUNT_W-1:0]    top_count;
    } t_booking;

    logic clk = 1'b0;
    logic rst_n;

    rds_job_if    job_bus();
    rds_result_if result_bus();
    rds_cfg_if    cfg_bus();

    room_dispatch_scheduler_unit #(
        .ROOMS(ROOMS_BUILT)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_job   (job_bus),
        .o_result(result_bus),
        .i_cfg   (cfg_bus)
    );

    // Predicted state of the rooms and the booking leader.
    logic [TIME_W-1:0]     room_free_at [ROOMS_BUILT];
    logic [COUNT_W-1:0]    room_uses    [ROOMS_BUILT];
    logic [ROOM_OUT_W-1:0] top_room;
    logic [COUNT_W-1:0]    top_count;
    logic [CFG_W-1:0]      room_setting;

    t_booking bookings_due[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       sender_idles   = 1'b1;
    bit       receiver_idles = 1'b1;

    always #1 clk = ~clk;

    // The run is cut off if it hangs.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // A setting of zero still uses one room, and settings above the build clamp to it.
    function automatic int active_rooms(input logic [CFG_W-1:0] setting);
        if (setting == 0) begin
            return 1;
        end
        if (setting > ROOMS_BUILT) begin
            return ROOMS_BUILT;
        end
        return int'(setting);
    endfunction

    // Books one job into the predicted rooms and returns the booking it should produce.
    function automatic t_booking dispatch_job(input logic [TIME_IN_W-1:0] start_t,
                                              input logic [TIME_IN_W-1:0] end_t);
        t_booking          booked;
        logic [TIME_W-1:0] start_wide;
        logic [TIME_W-1:0] length;
        logic [TIME_W-1:0] earliest;
        logic [TIME_W:0]   finish_sum;
        logic              found;
        int                rooms;
        int                pick;
        int                r;
        start_wide = {{(TIME_W - TIME_IN_W){1'b0}}, start_t};
        length     = '0;
        if (end_t > start_t) begin
            length = {{(TIME_W - TIME_IN_W){1'b0}}, end_t - start_t};
        end
        rooms    = active_rooms(room_setting);
        found    = 1'b0;
        pick     = 0;
        earliest = '0;

        // The first free room wins; otherwise the earliest to free, lower index on ties.
        for (r = 0; r < rooms; r++) begin
            if (!found) begin
                if (room_free_at[r] <= start_wide) begin
                    pick  = r;
                    found = 1'b1;
                end else if (r == 0 || room_free_at[r] < earliest) begin
                    earliest = room_free_at[r];
                    pick     = r;
                end
            end
        end

        booked.room     = pick[ROOM_OUT_W-1:0];
        booked.begins   = found ? start_wide : room_free_at[pick];
        finish_sum      = {1'b0, booked.begins} + {1'b0, length};
        booked.finishes = finish_sum[TIME_W] ? TIME_MAX : finish_sum[TIME_W-1:0];
        room_free_at[pick] = booked.finishes;

        // Use counts saturate, and the leader moves only on a strictly better count
        // or an equal count in a lower room.
        if (room_uses[pick] != COUNT_MAX) begin
            room_uses[pick] = room_uses[pick] + 1'b1;
        end
        if (room_uses[pick] > top_count ||
            (room_uses[pick] == top_count && pick < top_room)) begin
            top_count = room_uses[pick];
            top_room  = pick[ROOM_OUT_W-1:0];
        end
        booked.top_room  = top_room;
        booked.top_count = top_count;
        return booked;
    endfunction

    // Sends one job request and records the booking it should produce.
    task automatic send_job(input logic [TIME_IN_W-1:0] start_t,
                            input logic [TIME_IN_W-1:0] end_t);
        int gap;
        gap = sender_idles ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            job_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job_bus.valid      <= 1'b1;
        job_bus.start_time <= start_t;
        job_bus.end_time   <= end_t;
        do @(posedge clk); while (job_bus.ready !== 1'b1);
        bookings_due.push_back(dispatch_job(start_t, end_t));
    endtask

    // Holds off new requests until every booking has come back.
    task automatic wait_drained();
        job_bus.valid <= 1'b0;
        while (bookings_due.size() != 0) @(posedge clk);
    endtask

    // The room count is only changed while the block is idle.
    task automatic set_room_count(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_bus.valid      <= 1'b1;
        cfg_bus.room_count <= value;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        room_setting = value;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // Takes results with random stalls and compares each with the oldest booking due.
    initial begin : result_monitor
        int       stall;
        t_booking want;
        result_bus.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 8) : 0;
            if (stall != 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (result_bus.valid !== 1'b1);
            if (bookings_due.size() == 0) begin
                $error("result arrived with no request pending");
                mismatch_count++;
            end else begin
                want = bookings_due.pop_front();
                check_field("assigned_room", want.room, result_bus.assigned_room);
                check_field("actual_begin", want.begins, result_bus.actual_begin);
                check_field("actual_finish", want.finishes, result_bus.actual_finish);
                check_field("most_booked_room", want.top_room, result_bus.most_booked_room);
                check_field("most_booked_count", want.top_count,
                            result_bus.most_booked_count);
            end
        end
    end

    // Small times: free rooms, zero and negative lengths, delays and room count corners.
    task automatic test_directed_basics();
        send_job(32'd0, 32'd1);
        send_job(32'd0, 32'd0);
        send_job(32'd0, 32'd5);
        send_job(32'd3, 32'd2);
        send_job(32'd4, 32'd4);
        set_room_count(5'd2);
        send_job(32'd10, 32'd20);
        send_job(32'd10, 32'd20);
        send_job(32'd11, 32'd30);
        set_room_count(5'd0);
        send_job(32'd12, 32'd13);
        send_job(32'd12, 32'd13);
        set_room_count(5'd31);
        send_job(32'd15, 32'd16);
        send_job(32'd15, 32'd40);
        send_job(32'd9, 32'd12);
    endtask

    // Field extremes, out-of-order starts and delays that push times past 32 bits.
    task automatic test_directed_extremes();
        set_room_count(5'd2);
        send_job(32'd0, 32'hFFFF_FFFF);
        send_job(32'd0, 32'hFFFF_FFFF);
        send_job(32'd0, 32'hFFFF_FFFF);
        send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_job(32'hFFFF_FFFF, 32'd0);
        send_job(32'h8000_0000, 32'h7FFF_FFFF);
        set_room_count(5'd16);
        send_job(32'hAAAA_AAAA, 32'hD555_5555);
        send_job(32'h5555_5555, 32'hFFFF_FFFE);
    endtask

    // Room count per random phase; zero and values above the build are included.
    function automatic logic [CFG_W-1:0] phase_setting(input int phase);
        case (phase)
            0:       return 5'd16;
            1:       return 5'd3;
            2:       return 5'd7;
            3:       return 5'd1;
            4:       return 5'd0;
            5:       return 5'd31;
            6:       return 5'd12;
            default: return 5'd17;
        endcase
    endfunction

    // Mostly ordered arrivals with contention, plus a little out-of-order and odd-length noise.
    task automatic test_random_traffic(input int first_phase, input int last_phase);
        int                   phase;
        int                   n;
        int                   rooms;
        int                   kind;
        logic [TIME_IN_W-1:0] cursor;
        logic [TIME_IN_W-1:0] start_t;
        logic [TIME_IN_W-1:0] end_t;
        logic [TIME_IN_W:0]   reach;
        for (phase = first_phase; phase <= last_phase; phase++) begin
            set_room_count(phase_setting(phase));
            sender_idles   = !phase[0];
            receiver_idles = !phase[1];
            rooms  = active_rooms(room_setting);
            cursor = {phase[2:0], 29'd0} | $urandom_range(0, 32'h1FFF_FFFF);
            for (n = 0; n < PHASE_JOBS; n++) begin
                if (n != 0 && $urandom_range(0, 39) == 0) begin
                    wait_drained();
                end
                cursor  = cursor + $urandom_range(0, 12);
                kind    = $urandom_range(0, 127);
                start_t = (kind < 4) ? $urandom_range(0, cursor) : cursor;
                reach   = {1'b0, start_t} + $urandom_range(1, 6 * rooms + 6);
                end_t   = reach[TIME_IN_W] ? '1 : reach[TIME_IN_W-1:0];
                if (kind >= 4 && kind < 8) begin
                    end_t = start_t;
                end else if (kind >= 8 && kind < 12) begin
                    end_t = $urandom_range(0, start_t);
                end else if (kind == 12) begin
                    end_t = '1;
                end
                send_job(start_t, end_t);
            end
        end
    endtask

    // One room and maximal lengths, back to back, until the free time saturates.
    task automatic test_time_saturation();
        int n;
        set_room_count(5'd1);
        sender_idles   = 1'b0;
        receiver_idles = 1'b1;
        for (n = 0; n < SATURATE_JOBS; n++) begin
            send_job('0, '1);
        end
    endtask

    initial begin : run
        int r;
        for (r = 0; r < ROOMS_BUILT; r++) begin
            room_free_at[r] = '0;
            room_uses[r]    = '0;
        end
        top_room     = '0;
        top_count    = '0;
        room_setting = CFG_RESET;

        job_bus.valid      <= 1'b0;
        job_bus.start_time <= '0;
        job_bus.end_time   <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.room_count <= '0;
        rst_n              <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_basics();
        test_random_traffic(0, 3);
        test_directed_extremes();
        test_time_saturation();
        test_random_traffic(4, 7);

        // Let any stray result show up before the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && bookings_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/rds_pkg.sv
src/rds_if.sv
src/rds_ctrl.sv
src/rds_datapath.sv
src/room_dispatch_scheduler_unit.sv
dv/tb.sv
